/* hdl/spq_pkg.sv */
// Shared constants, codes and item types of the stable priority queue.
package spq_pkg;

    localparam int CAPACITY  = 16;
    localparam int PRIO_BITS = 8;
    localparam int DATA_BITS = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode                      opcode;
        logic signed [DATA_BITS-1:0]  data_in;
        logic        [PRIO_BITS-1:0]  prio_in;
    } t_spq_in;

    typedef struct packed {
        logic signed [DATA_BITS-1:0]  data_out;
        t_status                      status;
        logic signed [DATA_BITS-1:0]  front_data;
        logic                         is_empty;
        logic        [CNT_W-1:0]      entry_count;
    } t_spq_out;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                         shift_in;
        logic                         shift_out;
        logic signed [DATA_BITS-1:0]  data;
        logic        [PRIO_BITS-1:0]  prio;
    } t_spq_ctl;

endpackage

/* hdl/spq_cell.sv */
// One storage cell of the sorted chain: keeps, takes the new entry, or shifts.
module spq_cell (
    input  logic                                  i_clk,
    input  spq_pkg::t_spq_ctl                     i_ctl,
    input  logic                                  i_valid,
    input  logic                                  i_left_keep,
    input  logic signed [spq_pkg::DATA_BITS-1:0]  i_left_data,
    input  logic        [spq_pkg::PRIO_BITS-1:0]  i_left_prio,
    input  logic signed [spq_pkg::DATA_BITS-1:0]  i_right_data,
    input  logic        [spq_pkg::PRIO_BITS-1:0]  i_right_prio,
    output logic                                  o_keep,
    output logic signed [spq_pkg::DATA_BITS-1:0]  o_data,
    output logic        [spq_pkg::PRIO_BITS-1:0]  o_prio
);

    logic signed [spq_pkg::DATA_BITS-1:0] r_data, n_data;
    logic        [spq_pkg::PRIO_BITS-1:0] r_prio, n_prio;

    // An occupied cell whose priority does not exceed the new one stays put on an enqueue.
    assign o_keep = i_valid && (r_prio <= i_ctl.prio);

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctl.shift_in) begin
            if (!o_keep && i_left_keep) begin
                n_data = i_ctl.data;
                n_prio = i_ctl.prio;
            end else if (!o_keep) begin
                n_data = i_left_data;
                n_prio = i_left_prio;
            end
        end else if (i_ctl.shift_out) begin
            n_data = i_right_data;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data = r_data;
    assign o_prio = r_prio;

endmodule

/* hdl/stable_priority_queue_top.sv */
// Top level of the stable priority queue built as a chain of sorting cells.
//
//  Channel   Ports                      Direction  Transfer
//  command   start, busy, i_item        in         start high while busy low
//  result    o_done, o_result           out        o_done high for one cycle
//
// The chain of cells updates at the edge that accepts an item, and the
// result appears in the following cycle with o_done high. The cells decide
// locally and in parallel where the new entry lands, so the chain length
// sets only the fan-out of the command, not the cycle count. busy never
// rises, so a new item may follow in every cycle. Reset clears the entry
// count and the result strobe; cell contents are not cleared, since only
// cells below the count are ever read. The receiver cannot stall, so each
// result must be taken in the cycle it is shown.
module stable_priority_queue_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  spq_pkg::t_spq_in   i_item,
    output logic               o_done,
    output spq_pkg::t_spq_out  o_result
);

    logic                                  w_accept;
    logic                                  w_full;
    logic                                  w_empty;
    spq_pkg::t_spq_ctl                     w_ctl;

    logic                                  w_keep [spq_pkg::CAPACITY];
    logic signed [spq_pkg::DATA_BITS-1:0]  w_data [spq_pkg::CAPACITY];
    logic        [spq_pkg::PRIO_BITS-1:0]  w_prio [spq_pkg::CAPACITY];

    logic [spq_pkg::CNT_W-1:0]             r_count, n_count;
    logic                                  r_done, n_done;
    logic signed [spq_pkg::DATA_BITS-1:0]  r_data_out, n_data_out;
    spq_pkg::t_status                      r_status, n_status;

    // The queue finishes every item in the cycle it is taken.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    assign w_empty  = (r_count == '0);

    // The command to the chain only moves entries when the item really
    // changes the queue; dropped or empty-error items leave the cells alone.
    always_comb begin
        w_ctl.shift_in  = w_accept && (i_item.opcode == spq_pkg::OP_ENQ) && !w_full;
        w_ctl.shift_out = w_accept && (i_item.opcode == spq_pkg::OP_DEQ) && !w_empty;
        w_ctl.data      = i_item.data_in;
        w_ctl.prio      = i_item.prio_in;
    end

    // Each cell sees its left and right neighbors. The leftmost cell treats
    // its missing neighbor as a kept entry, so it takes a new entry that
    // belongs at the front. The rightmost cell refills from itself on a
    // dequeue; its content is then beyond the count and never read.
    for (genvar g = 0; g < spq_pkg::CAPACITY; g++) begin : g_cell
        logic                                  w_valid;
        logic                                  w_lkeep;
        logic signed [spq_pkg::DATA_BITS-1:0]  w_ldata;
        logic        [spq_pkg::PRIO_BITS-1:0]  w_lprio;
        logic signed [spq_pkg::DATA_BITS-1:0]  w_rdata;
        logic        [spq_pkg::PRIO_BITS-1:0]  w_rprio;

        assign w_valid = (r_count > spq_pkg::CNT_W'(g));

        if (g == 0) begin : g_left_end
            assign w_lkeep = 1'b1;
            assign w_ldata = i_item.data_in;
            assign w_lprio = i_item.prio_in;
        end else begin : g_left
            assign w_lkeep = w_keep[g-1];
            assign w_ldata = w_data[g-1];
            assign w_lprio = w_prio[g-1];
        end

        if (g == spq_pkg::CAPACITY - 1) begin : g_right_end
            assign w_rdata = w_data[g];
            assign w_rprio = w_prio[g];
        end else begin : g_right
            assign w_rdata = w_data[g+1];
            assign w_rprio = w_prio[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (w_valid),
            .i_left_keep  (w_lkeep),
            .i_left_data  (w_ldata),
            .i_left_prio  (w_lprio),
            .i_right_data (w_rdata),
            .i_right_prio (w_rprio),
            .o_keep       (w_keep[g]),
            .o_data       (w_data[g]),
            .o_prio       (w_prio[g])
        );
    end

    // Count, status and dequeued data of the item being taken.
    always_comb begin
        n_count    = r_count;
        n_done     = w_accept;
        n_data_out = r_data_out;
        n_status   = r_status;
        if (w_accept) begin
            n_data_out = '0;
            n_status   = spq_pkg::ST_OK;
            if (i_item.opcode == spq_pkg::OP_ENQ) begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + spq_pkg::CNT_W'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_data_out = w_data[0];
                    n_count    = r_count - spq_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_data_out <= n_data_out;
        r_status   <= n_status;
    end

    // The front entry and the count already reflect the finished item while
    // its result is shown.
    always_comb begin
        o_result.data_out    = r_data_out;
        o_result.status      = r_status;
        o_result.front_data  = (r_count != '0) ? w_data[0] : '0;
        o_result.is_empty    = (r_count == '0);
        o_result.entry_count = r_count;
    end

    assign o_done = r_done;

endmodule
